[design/mhpq_pkg.sv]
`default_nettype none
package mhpq_pkg;

  localparam int CAPACITY = 15;
  localparam int AW       = 4;   // store address bits, slots 1..CAPACITY
  localparam int CW       = 4;   // count bits
  localparam int IW       = 5;   // child index can step past the store

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] key;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] max_key;
    logic [CW-1:0]      entry_count;
    logic [2:0]         levels;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CMP,
    S_UP_FIN,
    S_DN_TOP,
    S_DN_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_FIN
  } state_t;

  // bit length of the count
  function automatic logic [2:0] level_count(input logic [CW-1:0] n);
    logic [2:0] c;
    c = 3'd0;
    for (int b = 0; b < CW; b++) begin
      if (n[b]) c = 3'(b + 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[design/mhpq_front.sv]
`default_nettype none
module mhpq_front import mhpq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               opcode,
  input  wire logic signed [31:0] key,
  output logic                    cmd_valid,
  output cmd_t                    cmd,
  input  wire logic               cmd_take
);

  cmd_t       slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic       do_push;
  logic       do_take;

  assign full      = (used == 2'd2);
  assign cmd_valid = (used != 2'd0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_take   = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr].op  <= op_t'(opcode);
      slots[wr_ptr].key <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_take) rd_ptr <= ~rd_ptr;
      used <= used + 2'(do_push) - 2'(do_take);
    end
  end

endmodule
`default_nettype wire

[design/mhpq_back.sv]
`default_nettype none
module mhpq_back import mhpq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_take
);

  logic signed [31:0] store [0:(1<<AW)-1];
  logic signed [31:0] rdata;
  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [IW-1:0]      idx, idx_next;     // insert slot, or parent on delete
  logic [IW-1:0]      chi, chi_next;     // child on delete
  logic signed [31:0] hold, hold_next;   // key being placed
  logic signed [31:0] top, top_next;
  logic signed [31:0] lv, lv_next;
  logic               finish;
  status_t            fin_status;
  logic signed [31:0] fin_key;
  logic signed [31:0] best;
  logic [IW-1:0]      best_idx;
  logic [IW-1:0]      c2;

  always_ff @(posedge clk) begin
    if (we) store[waddr] <= wdata;
    rdata <= store[raddr];
  end

  // larger child, left on a tie
  always_comb begin
    best     = lv;
    best_idx = chi;
    if (state == S_DN_R && lv < rdata) begin
      best     = rdata;
      best_idx = chi + IW'(1);
    end
    if (state == S_DN_L) best = rdata;
    c2 = {best_idx[IW-2:0], 1'b0};
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    chi_next   = chi;
    hold_next  = hold;
    top_next   = top;
    lv_next    = lv;
    raddr      = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = hold;
    cmd_take   = 1'b0;
    finish     = 1'b0;
    fin_status = ST_OK;
    fin_key    = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && !res_valid) begin
          cmd_take  = 1'b1;
          hold_next = cmd.key;
          if (cmd.op == OP_INSERT) begin
            if (count == CW'(CAPACITY)) begin
              finish     = 1'b1;
              fin_status = ST_FULL;
            end else begin
              count_next = count + CW'(1);
              idx_next   = IW'(count) + IW'(1);
              if (count == '0) begin
                we     = 1'b1;
                waddr  = AW'(1);
                wdata  = cmd.key;
                finish = 1'b1;
              end else begin
                raddr      = AW'(idx_next >> 1);
                state_next = S_UP_CMP;
              end
            end
          end else begin
            if (count == '0) begin
              finish     = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              raddr      = AW'(1);
              state_next = S_DN_TOP;
            end
          end
        end
      end
      S_UP_CMP: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        if (hold > rdata) begin
          wdata    = rdata;
          idx_next = idx >> 1;
          raddr    = AW'(idx_next >> 1);
          if (idx_next == IW'(1)) state_next = S_UP_FIN;
        end else begin
          wdata      = hold;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_UP_FIN: begin
        we         = 1'b1;
        waddr      = AW'(1);
        wdata      = hold;
        finish     = 1'b1;
        state_next = S_IDLE;
      end
      S_DN_TOP: begin
        top_next   = rdata;
        raddr      = count[AW-1:0];
        count_next = count - CW'(1);
        state_next = S_DN_LAST;
      end
      S_DN_LAST: begin
        hold_next = rdata;
        idx_next  = IW'(1);
        chi_next  = IW'(2);
        if (IW'(count) < IW'(2)) begin
          we         = 1'b1;
          waddr      = AW'(1);
          wdata      = rdata;
          finish     = 1'b1;
          fin_key    = top;
          state_next = S_IDLE;
        end else begin
          raddr      = AW'(2);
          state_next = S_DN_L;
        end
      end
      S_DN_L, S_DN_R: begin
        if (state == S_DN_L && chi < IW'(count)) begin
          lv_next    = rdata;
          raddr      = AW'(chi + IW'(1));
          state_next = S_DN_R;
        end else begin
          we    = 1'b1;
          waddr = idx[AW-1:0];
          if (hold >= best) begin
            wdata      = hold;
            finish     = 1'b1;
            fin_key    = top;
            state_next = S_IDLE;
          end else begin
            wdata    = best;
            idx_next = best_idx;
            chi_next = c2;
            raddr    = c2[AW-1:0];
            if (c2 > IW'(count)) state_next = S_DN_FIN;
            else                 state_next = S_DN_L;
          end
        end
      end
      S_DN_FIN: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        wdata      = hold;
        finish     = 1'b1;
        fin_key    = top;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (finish)        res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    chi  <= chi_next;
    hold <= hold_next;
    top  <= top_next;
    lv   <= lv_next;
    if (finish) begin
      res.status      <= fin_status;
      res.max_key     <= fin_key;
      res.entry_count <= count_next;
      res.levels      <= level_count(count_next);
    end
  end

endmodule
`default_nettype wire

[design/max_heap_priority_queue_unit.sv]
// Bounded max-heap priority queue, 15 signed 32-bit keys.
// Input channel: opcode (insert or delete max) and key, taken on a beat where
// push is high and full is low. A two-entry command queue sits in front of
// the heap engine, so a couple of commands can wait while one is worked.
// Result channel: status, max_key, entry_count and levels are valid while
// empty is low; a beat completes when pop is high. Exactly one result per
// command, in command order.
// Steps, from the command beat to empty going low with the engine free:
// refused commands and inserts into an empty heap finish straight from idle;
// other inserts make one compare per level climbed, plus a final write when
// the key reaches the root; a delete reads the root and then the last key,
// then reads both children per level examined (only the left where only a
// left child exists), plus a final write when the key sinks to the bottom.
// Every parent and child is one read of the key store. The engine takes the
// next command in the cycle after the result beat.
// Reset clears the count and all queues; store contents need no clearing.
// When the receiver stalls, the result holds and the engine waits before
// starting the next command; the command queue then fills and raises full.
`default_nettype none
module max_heap_priority_queue_unit import mhpq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               opcode,
  input  wire logic signed [31:0] key,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status,
  output logic signed [31:0]      max_key,
  output logic [3:0]              entry_count,
  output logic [2:0]              levels
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_valid;
  res_t res;

  mhpq_front u_front (
    .clk, .rst, .push, .full, .opcode, .key,
    .cmd_valid, .cmd, .cmd_take
  );

  mhpq_back u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take,
    .res_valid, .res, .res_take(pop)
  );

  assign empty       = !res_valid;
  assign status      = res.status;
  assign max_key     = res.max_key;
  assign entry_count = res.entry_count;
  assign levels      = res.levels;

endmodule
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic               opcode;
  logic signed [31:0] key;
  logic               empty;
  logic               pop;
  logic [1:0]         status;
  logic signed [31:0] max_key;
  logic [3:0]         entry_count;
  logic [2:0]         levels;

  max_heap_priority_queue_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode), .key(key),
    .empty(empty), .pop(pop), .status(status), .max_key(max_key),
    .entry_count(entry_count), .levels(levels)
  );

  // shadow heap, one-based like the block's store
  logic signed [31:0] heap_keys [1:CAPACITY];
  int unsigned        heap_fill;
  res_t               pending_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          inserts_sent;
  int          deletes_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TIMEOUT at %0t with %0d results pending", $time, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [2:0] bit_length(input int unsigned n);
    logic [2:0] c;
    c = 3'd0;
    while (n != 0) begin
      c = c + 3'd1;
      n = n >> 1;
    end
    return c;
  endfunction

  function automatic res_t heap_apply(input op_t op, input logic signed [31:0] k);
    res_t               r;
    int unsigned        i;
    int unsigned        p;
    int unsigned        c;
    logic signed [31:0] last;
    r = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_fill++;
        i = heap_fill;
        while (i != 1 && k > heap_keys[i/2]) begin
          heap_keys[i] = heap_keys[i/2];
          i = i / 2;
        end
        heap_keys[i] = k;
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.max_key = heap_keys[1];
        last = heap_keys[heap_fill];
        heap_fill--;
        p = 1;
        c = 2;
        while (c <= heap_fill) begin
          if (c < heap_fill && heap_keys[c] < heap_keys[c+1]) c++;
          if (last >= heap_keys[c]) break;
          heap_keys[p] = heap_keys[c];
          p = c;
          c = c * 2;
        end
        heap_keys[p] = last;
      end
    end
    r.entry_count = heap_fill[3:0];
    r.levels = bit_length(heap_fill);
    return r;
  endfunction

  task automatic send_cmd(input op_t op, input logic signed [31:0] k);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    opcode <= op;
    key    <= k;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(heap_apply(op, k));
    items_sent++;
    if (op == OP_INSERT) inserts_sent++;
    else deletes_sent++;
  endtask

  // receiver: drive pop, check each accepted beat
  initial begin
    res_t exp_res;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d max_key=%0d", $time, status, max_key);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
            error_count++;
          end
          if (max_key !== exp_res.max_key) begin
            $display("%0t: max_key expected %0d actual %0d", $time, exp_res.max_key, max_key);
            error_count++;
          end
          if (entry_count !== exp_res.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     exp_res.entry_count, entry_count);
            error_count++;
          end
          if (levels !== exp_res.levels) begin
            $display("%0t: levels expected %0d actual %0d", $time, exp_res.levels, levels);
            error_count++;
          end
        end
      end
      pop <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(6))) - 32'sd3;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic test_extremes();
    send_cmd(OP_DELETE, 32'sd0);           // delete on empty heap
    send_cmd(OP_DELETE, 32'shffffffff);
    send_cmd(OP_INSERT, 32'sh7fffffff);
    send_cmd(OP_INSERT, 32'sh80000000);
    send_cmd(OP_INSERT, 32'sh55555555);
    send_cmd(OP_INSERT, 32'shaaaaaaaa);
    send_cmd(OP_INSERT, 32'sh7fffffff);    // tie with the root
    repeat (5) send_cmd(OP_DELETE, 32'sd0);
  endtask

  task automatic test_full_and_ties();
    for (int n = 0; n < CAPACITY; n++) send_cmd(OP_INSERT, (n % 3 == 0) ? 32'sd7 : -n);
    send_cmd(OP_INSERT, 32'sh7fffffff);    // refused, heap full
    send_cmd(OP_INSERT, 32'sh80000000);
    repeat (CAPACITY + 1) send_cmd(OP_DELETE, 32'sd0);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned bias;
    for (int unsigned n = 0; n < n_items; n++) begin
      // drift between growing and draining so both full and empty recur
      bias = ((n / 40) % 2 == 0) ? 70 : 30;
      if ($urandom_range(99) < bias) send_cmd(OP_INSERT, rand_key());
      else send_cmd(OP_DELETE, $signed($urandom()));
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    opcode = 1'b0;
    key = '0;
    heap_fill = 0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    inserts_sent = 0;
    deletes_sent = 0;
    send_idle_pct = 32;
    recv_idle_pct = 87;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_full_and_ties();
    test_random(420);
    send_idle_pct = 87;
    recv_idle_pct = 32;
    test_random(420);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(440);
    drain();

    $display("Sent %0d commands (%0d inserts, %0d deletes), checked %0d results",
             items_sent, inserts_sent, deletes_sent, results_seen);
    $display("Covered empty and full refusals, key extremes, ties and three idle mixes");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
